// ===== rtl/core/ieee_sqrt_single_double_unit_assert.svh =====
// Assertion macros for the checker file.
`ifndef IEEE_SQRT_SINGLE_DOUBLE_UNIT_ASSERT_SVH
`define IEEE_SQRT_SINGLE_DOUBLE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SQRTSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sqrtsd check failed");

// Next-cycle implication.
`define SQRTSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sqrtsd check failed");

`endif

// ===== rtl/core/sqrtsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sqrtsd_pkg;

	localparam int SEED_ENTRIES = 128;
	localparam int SEED_IW      = $clog2(SEED_ENTRIES);

	localparam logic [31:0] THREE_Q = 32'hc0000000;
	localparam logic [63:0] THREE_D = 64'hc0000000_00000000;
	localparam logic [31:0] INF_S   = 32'h7f800000;
	localparam logic [63:0] INF_D   = 64'h7ff0000000000000;
	localparam logic [31:0] QNAN_S  = 32'h7fc00000;
	localparam logic [63:0] QNAN_D  = 64'h7ff8000000000000;

	localparam logic [15:0] SEED_TAB [SEED_ENTRIES] = '{
		16'hb451,16'hb2f0,16'hb196,16'hb044,16'haef9,16'hadb6,16'hac79,16'hab43,
		16'haa14,16'ha8eb,16'ha7c8,16'ha6aa,16'ha592,16'ha480,16'ha373,16'ha26b,
		16'ha168,16'ha06a,16'h9f70,16'h9e7b,16'h9d8a,16'h9c9d,16'h9bb5,16'h9ad1,
		16'h99f0,16'h9913,16'h983a,16'h9765,16'h9693,16'h95c4,16'h94f8,16'h9430,
		16'h936b,16'h92a9,16'h91ea,16'h912e,16'h9075,16'h8fbe,16'h8f0a,16'h8e59,
		16'h8daa,16'h8cfe,16'h8c54,16'h8bac,16'h8b07,16'h8a64,16'h89c4,16'h8925,
		16'h8889,16'h87ee,16'h8756,16'h86c0,16'h862b,16'h8599,16'h8508,16'h8479,
		16'h83ec,16'h8361,16'h82d8,16'h8250,16'h81c9,16'h8145,16'h80c2,16'h8040,
		16'hff02,16'hfd0e,16'hfb25,16'hf947,16'hf773,16'hf5aa,16'hf3ea,16'hf234,
		16'hf087,16'heee3,16'hed47,16'hebb3,16'hea27,16'he8a3,16'he727,16'he5b2,
		16'he443,16'he2dc,16'he17a,16'he020,16'hdecb,16'hdd7d,16'hdc34,16'hdaf1,
		16'hd9b3,16'hd87b,16'hd748,16'hd61a,16'hd4f1,16'hd3cd,16'hd2ad,16'hd192,
		16'hd07b,16'hcf69,16'hce5b,16'hcd51,16'hcc4a,16'hcb48,16'hca4a,16'hc94f,
		16'hc858,16'hc764,16'hc674,16'hc587,16'hc49d,16'hc3b7,16'hc2d4,16'hc1f4,
		16'hc116,16'hc03c,16'hbf65,16'hbe90,16'hbdbe,16'hbcef,16'hbc23,16'hbb59,
		16'hba91,16'hb9cc,16'hb90a,16'hb84a,16'hb78c,16'hb6d0,16'hb617,16'hb560
	};

	// Word state carried down the pipe; stages fill in fields as they go.
	typedef struct packed {
		logic        mode;
		logic        spec;
		logic        inv;
		logic [63:0] spec_res;
		logic [63:0] m;
		logic [10:0] ex;
		logic [31:0] r;
		logic [31:0] s;
		logic [31:0] u;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] sq32;
		logic [63:0] s64;
		logic [63:0] u64;
		logic [63:0] q;
		logic [63:0] sq64;
	} pipe_t;

	function automatic logic [63:0] mul_full(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = {32'd0, a} * {32'd0, b};
		return p;
	endfunction

	function automatic logic [31:0] mul_hi(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = mul_full(a, b);
		return p[63:32];
	endfunction

	// Position of the leading one of a fraction field.
	function automatic logic [5:0] msb_pos(input logic [51:0] f);
		logic [5:0] p;
		p = '0;
		for (int i = 1; i < 52; i++) begin
			if (f[i]) p = 6'(i);
		end
		return p;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sqrtsd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sqrtsd_front
	import sqrtsd_pkg::*;
(
	input  logic        mode,
	input  logic [63:0] operand,
	output pipe_t       word,
	output logic [31:0] seed
);

	logic [31:0]        ix;
	logic [31:0]        ixn;
	logic [31:0]        m32;
	logic [31:0]        eys;
	logic [5:0]         ps;
	logic [31:0]        fs;
	logic [63:0]        dx;
	logic [63:0]        dxn;
	logic [11:0]        top;
	logic [11:0]        topn;
	logic [11:0]        tsum;
	logic [5:0]         pd;
	logic [63:0]        fd;
	logic [63:0]        md;
	logic [SEED_IW-1:0] idx;

	always_comb begin
		word = '0;
		word.mode = mode;
		ix  = operand[31:0];
		dx  = operand;
		ixn = ix;
		dxn = dx;
		top = dx[63:52];
		topn = top;
		ps = msb_pos({29'd0, ix[22:0]});
		fs = {9'd0, ix[22:0]} << (6'd23 - ps);
		pd = msb_pos(dx[51:0]);
		fd = {12'd0, dx[51:0]} << (6'd52 - pd);
		if (!mode) begin
			if (ix - 32'h00800000 >= INF_S - 32'h00800000) begin
				if (ix[30:0] == '0 || ix == INF_S) begin
					word.spec = 1'b1;
					word.spec_res = {32'd0, ix};
				end else if (ix > INF_S) begin
					word.spec = 1'b1;
					word.inv  = 1'b1;
					word.spec_res = (ix[30:0] > INF_S[30:0]) ? {32'd0, ix | 32'h00400000}
						: {32'd0, QNAN_S};
				end else begin
					ixn = (({26'd0, ps + 6'd1} << 23) | (fs & 32'h007fffff)) - (32'd23 << 23);
				end
			end
			m32 = ixn[23] ? ({ixn[24:0], 7'd0} & 32'h7fffffff) : ({ixn[23:0], 8'd0} | 32'h80000000);
			eys = (ixn >> 1) + (32'h3f800000 >> 1);
			word.m  = {m32, 32'd0};
			word.ex = {3'd0, eys[30:23]};
			idx = ixn[23:17];
			md  = '0;
			tsum = '0;
		end else begin
			if (top == 12'd0 || top >= 12'h7ff) begin
				if (dx[62:0] == '0 || dx == INF_D) begin
					word.spec = 1'b1;
					word.spec_res = dx;
				end else if (dx > INF_D) begin
					word.spec = 1'b1;
					word.inv  = 1'b1;
					word.spec_res = (dx[62:0] > INF_D[62:0]) ? (dx | 64'h0008000000000000) : QNAN_D;
				end else begin
					dxn  = ({58'd0, pd + 6'd1} << 52) | (fd & 64'h000fffffffffffff);
					topn = {6'd0, pd + 6'd1} - 12'd52;
				end
			end
			md = {1'b1, dxn[51:0], 11'd0};
			if (topn[0]) md = md >> 1;
			tsum = topn + 12'h3ff;
			word.m  = md;
			word.ex = tsum[11:1];
			idx = dxn[52:46];
			m32 = '0;
			eys = '0;
		end
		seed = {SEED_TAB[idx], 16'd0};
	end

endmodule
`default_nettype wire

// ===== rtl/core/sqrtsd_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sqrtsd_round
	import sqrtsd_pkg::*;
(
	input  pipe_t       word,
	output logic [63:0] root,
	output logic        invalid
);

	logic [31:0] d0s;
	logic [31:0] d1s;
	logic [31:0] rs;
	logic [63:0] d0d;
	logic [63:0] d1d;
	logic [63:0] rd;

	always_comb begin
		// pick s or s + 1 ulp by the sign of the remainder test
		d0s = {word.m[47:32], 16'd0} - word.sq32;
		d1s = word.y - d0s;
		rs  = word.y + {31'd0, d1s[31]};
		d0d = {word.m[21:0], 42'd0} - word.sq64;
		d1d = word.q - d0d;
		rd  = word.q + {63'd0, d1d[63]};
		if (word.spec) root = word.spec_res;
		else if (word.mode) root = {1'b0, word.ex, rd[51:0]};
		else root = {32'd0, 1'b0, word.ex[7:0], rs[22:0]};
		invalid = word.inv;
	end

endmodule
`default_nettype wire

// ===== rtl/core/ieee_sqrt_single_double_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  tdata (low bit up)   tuser
// s_*       in   operand[63:0]        mode (0 binary32 in low half, 1 binary64)
// m_*       out  root[63:0]           invalid
//
// One word is taken every cycle while the output is not stalled.
// The depth is set by the chain of 32x32 multiplies in the Goldschmidt
// iterations, at most one multiply layer per stage.
// Reset clears only the stage valid bits; data registers are not reset.
// A stalled output freezes the whole pipe; s_tready drops in the same cycle.
module ieee_sqrt_single_double_unit
	import sqrtsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // operand[63:0]
	input  logic        s_tuser,  // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // root[63:0]
	output logic        m_tuser   // invalid
);

	localparam int NS = 10;

	logic        en;
	logic [NS:1] v_s;
	pipe_t       w_s1, w_s2, w_s3, w_s4, w_s5, w_s6, w_s7, w_s8, w_s9, w_s10;
	pipe_t       f_w, n1, n2, n3, n4, n5, n6, n7, n8, n9, n10;
	logic [31:0] f_seed;
	logic [63:0] r_root;
	logic        r_inv;
	logic [63:0] root_s11;
	logic        inv_s11;
	logic        v_s11;
	logic [31:0] d3, d5;
	logic [63:0] d8, s9;
	logic [63:0] c10;

	assign en       = !v_s11 || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_s11;
	assign m_tdata  = root_s11;
	assign m_tuser  = inv_s11;

	sqrtsd_front u_front (
		.mode    (s_tuser),
		.operand (s_tdata),
		.word    (f_w),
		.seed    (f_seed)
	);

	always_comb begin
		n1 = f_w;
		n1.r = f_seed;

		n2 = w_s1;
		n2.s = mul_hi(w_s1.m[63:32], w_s1.r);

		n3 = w_s2;
		d3 = mul_hi(w_s2.s, w_s2.r);
		n3.u = THREE_Q - d3;

		n4 = w_s3;
		n4.r = mul_hi(w_s3.r, w_s3.u) << 1;
		n4.s = mul_hi(w_s3.s, w_s3.u) << 1;

		n5 = w_s4;
		d5 = mul_hi(w_s4.s, w_s4.r);
		n5.u = THREE_Q - d5;

		// single takes the refined root s*u, double the refined reciprocal root r*u
		n6 = w_s5;
		n6.x = w_s5.mode ? (mul_hi(w_s5.r, w_s5.u) << 1) : mul_hi(w_s5.s, w_s5.u);

		n7 = w_s6;
		n7.y = (w_s6.x - 32'd1) >> 6;
		n7.sq32 = n7.y * n7.y;
		n7.s64 = mul_full(w_s6.m[63:32], w_s6.x)
			+ {32'd0, mul_hi(w_s6.m[31:0], w_s6.x)};

		n8 = w_s7;
		d8 = mul_full(w_s7.s64[63:32], w_s7.x) + {32'd0, mul_hi(w_s7.s64[31:0], w_s7.x)};
		n8.u64 = THREE_D - d8;

		n9 = w_s8;
		s9 = mul_full(w_s8.s64[63:32], w_s8.u64[63:32])
			+ {32'd0, mul_hi(w_s8.s64[63:32], w_s8.u64[31:0])}
			+ {32'd0, mul_hi(w_s8.s64[31:0], w_s8.u64[63:32])};
		n9.q = (s9 - 64'd2) >> 9;

		n10 = w_s9;
		c10 = mul_full(w_s9.q[63:32], w_s9.q[31:0]);
		n10.sq64 = mul_full(w_s9.q[31:0], w_s9.q[31:0]) + {c10[30:0], 33'd0};
	end

	sqrtsd_round u_round (
		.word    (w_s10),
		.root    (r_root),
		.invalid (r_inv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s   <= '0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s   <= {v_s[NS-1:1], s_tvalid};
			v_s11 <= v_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1     <= n1;
			w_s2     <= n2;
			w_s3     <= n3;
			w_s4     <= n4;
			w_s5     <= n5;
			w_s6     <= n6;
			w_s7     <= n7;
			w_s8     <= n8;
			w_s9     <= n9;
			w_s10    <= n10;
			root_s11 <= r_root;
			inv_s11  <= r_inv;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/sqrtsd_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "ieee_sqrt_single_double_unit_assert.svh"
module sqrtsd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tuser
);

	// hold output word while stalled
	`SQRTSD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// input side opens exactly when the output register can move
	`SQRTSD_ASSERT_NOW(a_ready_link, clk, arst_n, 1'b1, s_tready == (!m_tvalid || m_tready))

	// invalid results are always quiet NaNs of one of the two formats
	`SQRTSD_ASSERT_NOW(a_inv_nan, clk, arst_n, m_tvalid && m_tuser, (m_tdata[62:52] == 11'h7ff && m_tdata[51]) || (m_tdata[30:23] == 8'hff && m_tdata[22]))

endmodule

bind ieee_sqrt_single_double_unit sqrtsd_chk u_sqrtsd_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
